// File: design/tdu_pkg.sv
package tdu_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned LEVEL_W     = 5;
    localparam int unsigned BIT_IDX_W   = 4;
    localparam int unsigned DATA_BITS   = 8;
    localparam logic [7:0]  BIT_TICKS_RST = 8'd2;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 24;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_PUSH = 2'd1,
        ACT_POP  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        RX_WAIT = 2'd0,
        RX_DATA = 2'd1,
        RX_STOP = 2'd2
    } t_rx_phase;

    typedef enum logic [1:0] {
        TX_IDLE = 2'd0,
        TX_DATA = 2'd1,
        TX_STOP = 2'd2,
        TX_END  = 2'd3
    } t_tx_phase;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

endpackage

// File: design/tick_driven_uart_with_fifos.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------------
// s        | in        | i_s_tvalid/o_s_tready | tuser: action; tdata: rx_line, tx_byte
// m        | out       | o_m_tvalid/i_m_tready | tdata: tx_line, push_accepted, rx_byte,
//          |           |                     |        rx_valid, rx_level, tx_level
// cfg      | in        | i_cfg_valid/o_cfg_ready | bit_ticks
//
// One request per clock unless stalled: each accepted request updates the FIFO pointers,
// counters and line state in the same cycle; its result sits in the output register the
// cycle after. FIFO storage is two 16x8 synchronous RAMs, one registered read port each.
// Synchronous active-low reset clears pointers, counters and phases; the RAMs keep contents.
// A stalled result holds the input side only if the output register is still full.
module tick_driven_uart_with_fifos (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write: bit_ticks
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [7:0]                      i_cfg_data,
    // request: tuser = action[1:0]
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tdu_pkg::S_TUSER_W-1:0]   i_s_tuser,
    // request: tdata = rx_line[0], tx_byte[8:1], zero[15:9]
    input  logic [tdu_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // result: tdata = tx_line[0], push_accepted[1], rx_byte[9:2], rx_valid[10],
    //         rx_level[15:11], tx_level[20:16], zero[23:21]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [tdu_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import tdu_pkg::*;

    // configuration
    logic [7:0] r_bit_ticks;

    // FIFO storage and read data registers
    logic [7:0] r_rx_mem [QUEUE_DEPTH];
    logic [7:0] r_tx_mem [QUEUE_DEPTH];
    logic [7:0] r_rx_rdata;
    logic [7:0] r_tx_rdata;   // doubles as the transmit shift value

    // FIFO pointers
    logic [PTR_W-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [PTR_W-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [CNT_W-1:0] r_rx_count, n_rx_count, r_tx_count, n_tx_count;

    // receiver
    t_rx_phase              r_rx_phase, n_rx_phase;
    logic [7:0]             r_rx_shift, n_rx_shift;
    logic [BIT_IDX_W-1:0]   r_rx_idx, n_rx_idx;
    logic [7:0]             r_rx_ticks, n_rx_ticks;

    // transmitter
    t_tx_phase              r_tx_phase, n_tx_phase;
    logic [BIT_IDX_W-1:0]   r_tx_idx, n_tx_idx;
    logic [7:0]             r_tx_ticks, n_tx_ticks;
    logic                   r_line_out, n_line_out;

    // result register
    logic r_out_valid;
    logic r_out_acc, n_out_acc;
    logic r_out_rxv, n_out_rxv;

    // memory strobes
    logic rx_wr, tx_wr, rx_rd, tx_rd;

    logic       accept;
    t_action    action;
    logic       rx_line;
    logic [7:0] tx_byte;
    logic [7:0] rx_dec, tx_dec;
    logic [BIT_IDX_W-1:0] rx_idx_inc, tx_idx_inc;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;

    assign action  = t_action'(i_s_tuser);
    assign rx_line = i_s_tdata[0];
    assign tx_byte = i_s_tdata[8:1];

    assign rx_dec     = r_rx_ticks - 8'd1;
    assign tx_dec     = r_tx_ticks - 8'd1;
    assign rx_idx_inc = r_rx_idx + 1'b1;
    assign tx_idx_inc = r_tx_idx + 1'b1;

    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_rx_count = r_rx_count;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_count = r_tx_count;
        n_rx_phase = r_rx_phase;
        n_rx_shift = r_rx_shift;
        n_rx_idx   = r_rx_idx;
        n_rx_ticks = r_rx_ticks;
        n_tx_phase = r_tx_phase;
        n_tx_idx   = r_tx_idx;
        n_tx_ticks = r_tx_ticks;
        n_line_out = r_line_out;
        n_out_acc  = 1'b0;
        n_out_rxv  = 1'b0;
        rx_wr      = 1'b0;
        tx_wr      = 1'b0;
        rx_rd      = 1'b0;
        tx_rd      = 1'b0;

        unique case (action)
            ACT_TICK: begin
                // receive half of the tick
                unique case (r_rx_phase)
                    RX_WAIT: begin
                        if (!rx_line) begin
                            n_rx_shift = '0;
                            n_rx_idx   = '0;
                            n_rx_ticks = r_bit_ticks;
                            n_rx_phase = RX_DATA;
                        end
                    end
                    RX_DATA: begin
                        n_rx_ticks = rx_dec;
                        if (rx_dec == 8'd0) begin
                            if (rx_line) begin
                                n_rx_shift = r_rx_shift | (8'd1 << r_rx_idx[2:0]);
                            end
                            n_rx_idx   = rx_idx_inc;
                            n_rx_ticks = r_bit_ticks;
                            if (rx_idx_inc >= BIT_IDX_W'(DATA_BITS)) begin
                                n_rx_phase = RX_STOP;
                            end
                        end
                    end
                    default: begin
                        // stop bit: queue only a high stop with room left
                        n_rx_ticks = rx_dec;
                        if (rx_dec == 8'd0) begin
                            if (rx_line && (r_rx_count < CNT_W'(QUEUE_DEPTH))) begin
                                rx_wr      = 1'b1;
                                n_rx_tail  = next_ptr(r_rx_tail);
                                n_rx_count = r_rx_count + 1'b1;
                            end
                            n_rx_phase = RX_WAIT;
                        end
                    end
                endcase

                // transmit half of the tick
                if (r_tx_phase == TX_IDLE) begin
                    if (r_tx_count != '0) begin
                        // fetch the byte; it lands in r_tx_rdata for the data bits
                        tx_rd      = 1'b1;
                        n_tx_head  = next_ptr(r_tx_head);
                        n_tx_count = r_tx_count - 1'b1;
                        n_tx_idx   = '0;
                        n_tx_ticks = r_bit_ticks;
                        n_line_out = 1'b0;
                        n_tx_phase = TX_DATA;
                    end
                end else begin
                    n_tx_ticks = tx_dec;
                    if (tx_dec == 8'd0) begin
                        n_tx_ticks = r_bit_ticks;
                        unique case (r_tx_phase)
                            TX_DATA: begin
                                n_line_out = r_tx_rdata[r_tx_idx[2:0]];
                                n_tx_idx   = tx_idx_inc;
                                if (tx_idx_inc >= BIT_IDX_W'(DATA_BITS)) begin
                                    n_tx_phase = TX_STOP;
                                end
                            end
                            TX_STOP: begin
                                n_line_out = 1'b1;
                                n_tx_phase = TX_END;
                            end
                            default: begin
                                n_tx_phase = TX_IDLE;
                            end
                        endcase
                    end
                end
            end
            ACT_PUSH: begin
                if (r_tx_count < CNT_W'(QUEUE_DEPTH)) begin
                    tx_wr      = 1'b1;
                    n_tx_tail  = next_ptr(r_tx_tail);
                    n_tx_count = r_tx_count + 1'b1;
                    n_out_acc  = 1'b1;
                end
            end
            ACT_POP: begin
                if (r_rx_count != '0) begin
                    rx_rd      = 1'b1;
                    n_rx_head  = next_ptr(r_rx_head);
                    n_rx_count = r_rx_count - 1'b1;
                    n_out_rxv  = 1'b1;
                end
            end
            default: begin
                // unused code: report levels and line only
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_ticks <= BIT_TICKS_RST;
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_count  <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_count  <= '0;
            r_rx_phase  <= RX_WAIT;
            r_rx_shift  <= '0;
            r_rx_idx    <= '0;
            r_rx_ticks  <= '0;
            r_tx_phase  <= TX_IDLE;
            r_tx_idx    <= '0;
            r_tx_ticks  <= '0;
            r_line_out  <= 1'b1;
            r_out_valid <= 1'b0;
            r_out_acc   <= 1'b0;
            r_out_rxv   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bit_ticks <= i_cfg_data;
            end
            if (accept) begin
                r_rx_head  <= n_rx_head;
                r_rx_tail  <= n_rx_tail;
                r_rx_count <= n_rx_count;
                r_tx_head  <= n_tx_head;
                r_tx_tail  <= n_tx_tail;
                r_tx_count <= n_tx_count;
                r_rx_phase <= n_rx_phase;
                r_rx_shift <= n_rx_shift;
                r_rx_idx   <= n_rx_idx;
                r_rx_ticks <= n_rx_ticks;
                r_tx_phase <= n_tx_phase;
                r_tx_idx   <= n_tx_idx;
                r_tx_ticks <= n_tx_ticks;
                r_line_out <= n_line_out;
                r_out_acc  <= n_out_acc;
                r_out_rxv  <= n_out_rxv;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // receive FIFO RAM: write on a good stop bit, read on pop
    always_ff @(posedge i_clk) begin
        if (accept && rx_wr) begin
            r_rx_mem[r_rx_tail] <= r_rx_shift;
        end
        if (accept && rx_rd) begin
            r_rx_rdata <= r_rx_mem[r_rx_head];
        end
    end

    // transmit FIFO RAM: write on push, read when a frame starts
    always_ff @(posedge i_clk) begin
        if (accept && tx_wr) begin
            r_tx_mem[r_tx_tail] <= tx_byte;
        end
        if (accept && tx_rd) begin
            r_tx_rdata <= r_tx_mem[r_tx_head];
        end
    end

    // the state registers change only on accept, so they carry the latest result
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        3'b000,
        LEVEL_W'(r_tx_count),
        LEVEL_W'(r_rx_count),
        r_out_rxv,
        r_out_rxv ? r_rx_rdata : 8'd0,
        r_out_acc,
        r_line_out
    };

endmodule
